/* rtl/rdsps_pkg.sv */
`default_nettype none
package rdsps_pkg;

  localparam int unsigned NameLen = 8;
  localparam int unsigned TextLen = 64;

  localparam logic [1:0] ActDecode   = 2'd0;
  localparam logic [1:0] ActReadName = 2'd1;
  localparam logic [1:0] ActReadText = 2'd2;
  localparam logic [1:0] ActReset    = 2'd3;

  localparam logic [3:0] GrpName = 4'h0;
  localparam logic [3:0] GrpText = 4'h2;

  localparam logic [6:0] CharSpace = 7'h20;
  localparam logic [7:0] CharLow   = 8'd32;
  localparam logic [7:0] CharHigh  = 8'd126;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] block_b;
    logic [15:0] block_c;
    logic [15:0] block_d;
    logic [5:0]  read_position;
  } req_t;

  typedef struct packed {
    logic [6:0] read_char;
    logic       name_changed;
    logic       text_changed;
    logic       ab_state;
  } res_t;

  function automatic logic [6:0] printable(input logic [7:0] c);
    printable = (c < CharLow || c > CharHigh) ? CharSpace : c[6:0];
  endfunction

endpackage
`default_nettype wire

/* rtl/rds_ps_radiotext_decoder_unit.sv */
// Handshake: a request is taken when start is high and busy is low; its result
// strobes on done_o once its last character is handled: a read handles one
// character, a name or 2B update two and a 2A update four; reset actions and
// ignored groups answer in the cycle after they are taken. One request at a time;
// each character: StRead reads the single-port memory, StMod compares and writes back.
// Reset: rst_ni clears valid bits, flags and control at once; the receiver cannot stall.
`default_nettype none
module rds_ps_radiotext_decoder_unit (
  input  wire                logic clk_i,
  input  wire                logic rst_ni,
  input  wire                logic start,
  output                     logic busy,
  input  rdsps_pkg::req_t    req_i,
  output                     logic done_o,
  output rdsps_pkg::res_t    res_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRead = 2'd1;
  localparam logic [1:0] StMod  = 2'd2;

  logic [1:0]  state_q, state_d;
  logic [1:0]  k_q, k_d;
  logic [1:0]  last_q, last_d;
  logic        tgt_text_q, tgt_text_d;
  logic        is_read_q, is_read_d;
  rdsps_pkg::req_t req_q, req_d;

  logic [rdsps_pkg::NameLen-1:0] name_vld_q, name_vld_d;
  logic [rdsps_pkg::TextLen-1:0] text_vld_q, text_vld_d;
  logic ab_q, ab_d;
  logic name_dirty_q, name_dirty_d;
  logic text_dirty_q, text_dirty_d;
  logic [6:0] char_q, char_d;
  logic done_q, done_d;

  logic [6:0] name_mem [rdsps_pkg::NameLen];
  logic [6:0] text_mem [rdsps_pkg::TextLen];
  logic [6:0] name_rd_q;
  logic [6:0] text_rd_q;

  logic [5:0]  addr;
  logic [15:0] word;
  logic [7:0]  byte_in;
  logic [6:0]  wch;
  logic [6:0]  old_ch;
  logic        name_we;
  logic        text_we;
  logic        accept;

  assign accept = start && (state_q == StIdle);
  assign busy   = (state_q != StIdle);

  always_comb begin
    if (is_read_q) begin
      addr = req_q.read_position;
    end else if (!tgt_text_q) begin
      addr = {3'b000, req_q.block_b[1:0], k_q[0]};
    end else if (!req_q.block_b[11]) begin
      addr = {req_q.block_b[3:0], k_q};
    end else begin
      addr = {1'b0, req_q.block_b[3:0], k_q[0]};
    end
    word    = (tgt_text_q && !req_q.block_b[11] && !k_q[1]) ? req_q.block_c
                                                             : req_q.block_d;
    byte_in = k_q[0] ? word[7:0] : word[15:8];
    wch     = rdsps_pkg::printable(byte_in);
    if (tgt_text_q) begin
      old_ch = text_vld_q[addr] ? text_rd_q : rdsps_pkg::CharSpace;
    end else begin
      old_ch = name_vld_q[addr[2:0]] ? name_rd_q : rdsps_pkg::CharSpace;
    end
  end

  always_comb begin
    state_d      = state_q;
    k_d          = k_q;
    last_d       = last_q;
    tgt_text_d   = tgt_text_q;
    is_read_d    = is_read_q;
    req_d        = req_q;
    name_vld_d   = name_vld_q;
    text_vld_d   = text_vld_q;
    ab_d         = ab_q;
    name_dirty_d = name_dirty_q;
    text_dirty_d = text_dirty_q;
    char_d       = char_q;
    done_d       = 1'b0;
    name_we      = 1'b0;
    text_we      = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          req_d  = req_i;
          k_d    = 2'd0;
          char_d = rdsps_pkg::CharSpace;
          unique case (req_i.action)
            rdsps_pkg::ActDecode: begin
              is_read_d = 1'b0;
              if (req_i.block_b[15:12] == rdsps_pkg::GrpName) begin
                tgt_text_d = 1'b0;
                last_d     = 2'd1;
                state_d    = StRead;
              end else if (req_i.block_b[15:12] == rdsps_pkg::GrpText) begin
                if (req_i.block_b[4] != ab_q) begin
                  text_vld_d   = '0;
                  ab_d         = req_i.block_b[4];
                  text_dirty_d = 1'b1;
                end
                tgt_text_d = 1'b1;
                last_d     = req_i.block_b[11] ? 2'd1 : 2'd3;
                state_d    = StRead;
              end else begin
                done_d = 1'b1;
              end
            end
            rdsps_pkg::ActReadName: begin
              is_read_d  = 1'b1;
              tgt_text_d = 1'b0;
              last_d     = 2'd0;
              state_d    = StRead;
            end
            rdsps_pkg::ActReadText: begin
              is_read_d  = 1'b1;
              tgt_text_d = 1'b1;
              last_d     = 2'd0;
              state_d    = StRead;
            end
            default: begin
              name_vld_d   = '0;
              text_vld_d   = '0;
              ab_d         = 1'b0;
              name_dirty_d = 1'b0;
              text_dirty_d = 1'b0;
              done_d       = 1'b1;
            end
          endcase
        end
      end
      StRead: begin
        state_d = StMod;
      end
      StMod: begin
        if (is_read_q) begin
          char_d = old_ch;
        end else if (wch != old_ch) begin
          if (tgt_text_q) begin
            text_we            = 1'b1;
            text_vld_d[addr]   = 1'b1;
            text_dirty_d       = 1'b1;
          end else begin
            name_we                 = 1'b1;
            name_vld_d[addr[2:0]]   = 1'b1;
            name_dirty_d            = 1'b1;
          end
        end
        if (k_q == last_q) begin
          done_d  = 1'b1;
          state_d = StIdle;
        end else begin
          k_d     = k_q + 2'd1;
          state_d = StRead;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      k_q          <= 2'd0;
      last_q       <= 2'd0;
      tgt_text_q   <= 1'b0;
      is_read_q    <= 1'b0;
      name_vld_q   <= '0;
      text_vld_q   <= '0;
      ab_q         <= 1'b0;
      name_dirty_q <= 1'b0;
      text_dirty_q <= 1'b0;
      char_q       <= rdsps_pkg::CharSpace;
      done_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      k_q          <= k_d;
      last_q       <= last_d;
      tgt_text_q   <= tgt_text_d;
      is_read_q    <= is_read_d;
      name_vld_q   <= name_vld_d;
      text_vld_q   <= text_vld_d;
      ab_q         <= ab_d;
      name_dirty_q <= name_dirty_d;
      text_dirty_q <= text_dirty_d;
      char_q       <= char_d;
      done_q       <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
  end

  always_ff @(posedge clk_i) begin
    if (name_we) begin
      name_mem[addr[2:0]] <= wch;
    end
    name_rd_q <= name_mem[addr[2:0]];
  end

  always_ff @(posedge clk_i) begin
    if (text_we) begin
      text_mem[addr] <= wch;
    end
    text_rd_q <= text_mem[addr];
  end

  assign done_o = done_q;
  assign res_o  = {char_q, name_dirty_q, text_dirty_q, ab_q};

endmodule
`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps
module tb;

  localparam logic VerA = 1'b0;
  localparam int unsigned RandomCount = 1350;
  localparam int unsigned IdleLimit = 500;
  localparam int unsigned DrainCycles = 16;

  typedef struct {
    rdsps_pkg::req_t r;
    bit              typed;
    rdsps_pkg::res_t want;
  } row_t;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  rdsps_pkg::req_t req_i;
  logic done_o;
  rdsps_pkg::res_t res_o;

  logic [6:0] station_chars [rdsps_pkg::NameLen];
  logic [6:0] text_chars [rdsps_pkg::TextLen];
  logic       text_ab;
  logic       name_dirty;
  logic       text_dirty;

  rdsps_pkg::res_t pending_status [$];
  int   errors = 0;
  int   idle_cycles = 0;

  row_t directed_rows [25] = '{
    '{'{rdsps_pkg::ActReadName, 16'h0000, 16'h0000, 16'h0000, 6'd0}, 1'b1,
      '{rdsps_pkg::CharSpace, 1'b0, 1'b0, 1'b0}},
    '{'{rdsps_pkg::ActReadText, 16'hFFFF, 16'hFFFF, 16'hFFFF, 6'd63}, 1'b1,
      '{rdsps_pkg::CharSpace, 1'b0, 1'b0, 1'b0}},
    '{'{rdsps_pkg::ActDecode, 16'h0003, 16'hFFFF, 16'h4142, 6'd0}, 1'b1,
      '{rdsps_pkg::CharSpace, 1'b1, 1'b0, 1'b0}},
    '{'{rdsps_pkg::ActReadName, 16'h0000, 16'h0000, 16'h0000, 6'd14}, 1'b1,
      '{7'h41, 1'b1, 1'b0, 1'b0}},
    '{'{rdsps_pkg::ActDecode, 16'h0800, 16'h0000, 16'h1F7F, 6'd0}, 1'b1,
      '{rdsps_pkg::CharSpace, 1'b1, 1'b0, 1'b0}},
    '{'{rdsps_pkg::ActReset, 16'hFFFF, 16'hFFFF, 16'hFFFF, 6'd63}, 1'b1,
      '{rdsps_pkg::CharSpace, 1'b0, 1'b0, 1'b0}},
    '{'{rdsps_pkg::ActDecode, 16'h200F, 16'h7E20, 16'h8031, 6'd0}, 1'b1,
      '{rdsps_pkg::CharSpace, 1'b0, 1'b1, 1'b0}},
    '{'{rdsps_pkg::ActReadText, 16'h0000, 16'h0000, 16'h0000, 6'd60}, 1'b1,
      '{7'h7E, 1'b0, 1'b1, 1'b0}},
    '{'{rdsps_pkg::ActReadText, 16'h0000, 16'h0000, 16'h0000, 6'd63}, 1'b1,
      '{7'h31, 1'b0, 1'b1, 1'b0}},
    '{'{rdsps_pkg::ActDecode, 16'h2810, 16'h0000, 16'h2020, 6'd0}, 1'b1,
      '{rdsps_pkg::CharSpace, 1'b0, 1'b1, 1'b1}},
    '{'{rdsps_pkg::ActReadText, 16'h0000, 16'h0000, 16'h0000, 6'd60}, 1'b1,
      '{rdsps_pkg::CharSpace, 1'b0, 1'b1, 1'b1}},
    '{'{rdsps_pkg::ActReset, 16'h0000, 16'h0000, 16'h0000, 6'd0}, 1'b1,
      '{rdsps_pkg::CharSpace, 1'b0, 1'b0, 1'b0}},
    '{'{rdsps_pkg::ActDecode, 16'h2810, 16'h0000, 16'h2020, 6'd0}, 1'b1,
      '{rdsps_pkg::CharSpace, 1'b0, 1'b1, 1'b1}},
    '{'{rdsps_pkg::ActReset, 16'h0000, 16'h0000, 16'h0000, 6'd0}, 1'b1,
      '{rdsps_pkg::CharSpace, 1'b0, 1'b0, 1'b0}},
    '{'{rdsps_pkg::ActDecode, 16'h280F, 16'hABCD, 16'h2020, 6'd0}, 1'b1,
      '{rdsps_pkg::CharSpace, 1'b0, 1'b0, 1'b0}},
    '{'{rdsps_pkg::ActDecode, 16'hF7EF, 16'h4142, 16'h4344, 6'd0}, 1'b1,
      '{rdsps_pkg::CharSpace, 1'b0, 1'b0, 1'b0}},
    '{'{rdsps_pkg::ActDecode, 16'h1FFF, 16'h4142, 16'h4344, 6'd0}, 1'b1,
      '{rdsps_pkg::CharSpace, 1'b0, 1'b0, 1'b0}},
    '{'{rdsps_pkg::ActDecode, 16'h201F, 16'hFFFF, 16'hFFFF, 6'd0}, 1'b1,
      '{rdsps_pkg::CharSpace, 1'b0, 1'b1, 1'b1}},
    '{'{rdsps_pkg::ActDecode, 16'h07E6, 16'h1234, 16'h5A30, 6'd0}, 1'b0, '0},
    '{'{rdsps_pkg::ActReadName, 16'hFFFF, 16'hFFFF, 16'hFFFF, 6'd60}, 1'b0, '0},
    '{'{rdsps_pkg::ActDecode, 16'h2813, 16'h0000, 16'h4869, 6'd0}, 1'b0, '0},
    '{'{rdsps_pkg::ActReadText, 16'h0000, 16'h0000, 16'h0000, 6'd7}, 1'b0, '0},
    '{'{rdsps_pkg::ActDecode, 16'h2017, 16'h7E7F, 16'h2141, 6'd0}, 1'b0, '0},
    '{'{rdsps_pkg::ActReadText, 16'h0000, 16'h0000, 16'h0000, 6'd31}, 1'b0, '0},
    '{'{rdsps_pkg::ActReset, 16'h5A5A, 16'hA5A5, 16'h0F0F, 6'd42}, 1'b1,
      '{rdsps_pkg::CharSpace, 1'b0, 1'b0, 1'b0}}
  };

  rds_ps_radiotext_decoder_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .res_o  (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [6:0] keep_printable(input logic [7:0] b);
    return (b >= 8'd32 && b <= 8'd126) ? b[6:0] : rdsps_pkg::CharSpace;
  endfunction

  function automatic void clear_model();
    for (int i = 0; i < rdsps_pkg::NameLen; i++) station_chars[i] = rdsps_pkg::CharSpace;
    for (int i = 0; i < rdsps_pkg::TextLen; i++) text_chars[i] = rdsps_pkg::CharSpace;
    text_ab = 1'b0;
    name_dirty = 1'b0;
    text_dirty = 1'b0;
  endfunction

  function automatic void put_name_char(input logic [2:0] pos, input logic [7:0] b);
    logic [6:0] ch;
    ch = keep_printable(b);
    if (station_chars[pos] != ch) begin
      station_chars[pos] = ch;
      name_dirty = 1'b1;
    end
  endfunction

  function automatic void put_text_char(input logic [5:0] pos, input logic [7:0] b);
    logic [6:0] ch;
    ch = keep_printable(b);
    if (text_chars[pos] != ch) begin
      text_chars[pos] = ch;
      text_dirty = 1'b1;
    end
  endfunction

  function automatic rdsps_pkg::res_t decode_step(input rdsps_pkg::req_t r);
    rdsps_pkg::res_t o;
    logic [3:0] idx;
    o = '0;
    o.read_char = rdsps_pkg::CharSpace;
    idx = r.block_b[3:0];
    case (r.action)
      rdsps_pkg::ActDecode: begin
        if (r.block_b[15:12] == rdsps_pkg::GrpName) begin
          put_name_char({r.block_b[1:0], 1'b0}, r.block_d[15:8]);
          put_name_char({r.block_b[1:0], 1'b1}, r.block_d[7:0]);
        end else if (r.block_b[15:12] == rdsps_pkg::GrpText) begin
          if (r.block_b[4] != text_ab) begin
            for (int i = 0; i < rdsps_pkg::TextLen; i++) text_chars[i] = rdsps_pkg::CharSpace;
            text_ab = r.block_b[4];
            text_dirty = 1'b1;
          end
          if (r.block_b[11] == VerA) begin
            put_text_char({idx, 2'd0}, r.block_c[15:8]);
            put_text_char({idx, 2'd1}, r.block_c[7:0]);
            put_text_char({idx, 2'd2}, r.block_d[15:8]);
            put_text_char({idx, 2'd3}, r.block_d[7:0]);
          end else begin
            put_text_char({1'b0, idx, 1'b0}, r.block_d[15:8]);
            put_text_char({1'b0, idx, 1'b1}, r.block_d[7:0]);
          end
        end
      end
      rdsps_pkg::ActReadName: o.read_char = station_chars[r.read_position[2:0]];
      rdsps_pkg::ActReadText: o.read_char = text_chars[r.read_position];
      default: clear_model();
    endcase
    o.name_changed = name_dirty;
    o.text_changed = text_dirty;
    o.ab_state = text_ab;
    return o;
  endfunction

  function automatic logic [7:0] random_char();
    if ($urandom_range(0, 6) == 0) return 8'($urandom);
    return 8'($urandom_range(32, 126));
  endfunction

  function automatic rdsps_pkg::req_t random_request();
    rdsps_pkg::req_t r;
    int unsigned pick;
    r.block_b = 16'($urandom);
    r.block_c = {random_char(), random_char()};
    r.block_d = {random_char(), random_char()};
    r.read_position = 6'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      r.action = rdsps_pkg::ActReset;
    end else if (pick < 40) begin
      r.action = $urandom_range(0, 2) == 0 ? rdsps_pkg::ActReadName
                                           : rdsps_pkg::ActReadText;
    end else begin
      r.action = rdsps_pkg::ActDecode;
      pick = $urandom_range(0, 19);
      if (pick < 7) begin
        r.block_b[15:12] = rdsps_pkg::GrpName;
      end else if (pick < 17) begin
        r.block_b[15:12] = rdsps_pkg::GrpText;
        r.block_b[4] = ($urandom_range(0, 9) == 0) ? ~text_ab : text_ab;
      end
    end
    return r;
  endfunction

  task automatic send_request(input rdsps_pkg::req_t r, input bit typed,
                              input rdsps_pkg::res_t want);
    rdsps_pkg::res_t predicted;
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    predicted = decode_step(r);
    pending_status.push_back(typed ? want : predicted);
  endtask

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t %s mismatch: expected %0h, actual %0h", $time, what, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    rdsps_pkg::res_t want;
    if (rst_ni && done_o) begin
      if (pending_status.size() == 0) begin
        $display("%0t unexpected result: expected none, actual %0h", $time, res_o);
        errors++;
      end else begin
        want = pending_status.pop_front();
        check_field("read_char", want.read_char, res_o.read_char);
        check_field("name_changed", want.name_changed, res_o.name_changed);
        check_field("text_changed", want.text_changed, res_o.text_changed);
        check_field("ab_state", want.ab_state, res_o.ab_state);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || !rst_ni) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int burst_left;
    int gap;
    rst_ni = 1'b0;
    start = 1'b0;
    req_i = '0;
    burst_left = 0;
    clear_model();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < $size(directed_rows); i++) begin
      send_request(directed_rows[i].r, directed_rows[i].typed, directed_rows[i].want);
    end
    for (int i = 0; i < RandomCount; i++) begin
      send_request(random_request(), 1'b0, '0);
      if (burst_left == 0) begin
        gap = $urandom_range(1, 12);
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                 : $urandom_range(1, 20);
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end else begin
        burst_left--;
      end
    end
    start <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/rdsps_pkg.sv
rtl/rds_ps_radiotext_decoder_unit.sv
tb/tb.sv
